@@ sv/assert_macros.svh @@
// Assertion macros shared by the lane averager RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check with reset disable and a caller message.
`define LSA_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check with reset disable and a fixed message.
`define LSA_ASSERT(lbl, clk, rst_n, prop) \
    `LSA_ASSERT_MSG(lbl, clk, rst_n, prop, "lane averager check failed")

`endif

@@ sv/lsa_pkg.sv @@
// Types, constants and sequencer states of the lane segment averager.
// No dependencies; imported by lsa_div and lane_segment_averager_core.
`timescale 1ns / 1ps

package lsa_pkg;

    // Sizing
    localparam int MAX_SEGMENTS = 256;
    localparam int COORD_W      = 12;
    localparam int OUT_W        = 16;
    localparam int CFG_W        = 12;
    localparam int CFG_IDX_W    = 1;
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int SUM_W        = COORD_W + $clog2(MAX_SEGMENTS);
    localparam int DIFF_W       = COORD_W + 1;
    localparam int ACC_W        = 2 * DIFF_W + 1;
    localparam int NUM_W        = (2 * COORD_W + 1 > SUM_W) ? 2 * COORD_W + 1 : SUM_W;
    localparam int DEN_W        = (COORD_W > CNT_W) ? COORD_W : CNT_W;
    localparam int DIV_CNT_W    = $clog2(NUM_W);

    // Register reset values
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(540);
    localparam logic [CFG_W-1:0] TOP_ROW_RST      = CFG_W'(324);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_ROW      = CFG_IDX_W'(1);

    // Input transaction
    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic               last_segment;
    } t_seg;

    // Result transaction
    typedef struct packed {
        logic signed [OUT_W-1:0] left_top_x;
        logic signed [OUT_W-1:0] left_bottom_x;
        logic signed [OUT_W-1:0] right_top_x;
        logic signed [OUT_W-1:0] right_bottom_x;
        logic                    left_valid;
        logic                    right_valid;
    } t_res;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } t_div_rsp;

    // Frame-end sequencer
    typedef enum logic [3:0] {
        S_IDLE,
        S_SIDE,
        S_MEAN,
        S_MEAN_WT,
        S_SLOPE,
        S_MULA,
        S_MULB,
        S_XDIV,
        S_XDIV_WT,
        S_OUT
    } t_lsa_state;

endpackage

@@ sv/lsa_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lsa_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module lsa_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lsa_pkg::t_div_req i_req,
    output lsa_pkg::t_div_rsp o_rsp
);
    import lsa_pkg::*;

    logic                 r_run;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_dvs;
    logic [NUM_W-1:0]     r_quo;

    logic [DEN_W:0]       shifted;
    logic [DEN_W+1:0]     diff;
    logic                 ge;

    // Trial subtract of the divisor from the shifted remainder
    assign shifted = {r_rem, r_quo[NUM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_dvs};
    assign ge      = !diff[DEN_W+1];

    // Control: load on start, count steps, pulse done on the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(NUM_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift dividend in, quotient bits out
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_run) begin
            r_quo <= {r_quo[NUM_W-2:0], ge};
            r_rem <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

@@ sv/lane_segment_averager_core.sv @@
// Lane segment averager: accumulates segment endpoints per side, one per cycle while busy is low.
// A segment without the frame-end mark is taken when presented and busy stays low.
// The frame-end segment raises busy while the shared one-bit-per-cycle divider works out
// up to four means and two positions per side; the last busy cycle carries the result strobe,
// and a new segment is taken the next cycle.
// Reset (synchronous, active low) clears sums and counts and loads default rows.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lane_segment_averager_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  lsa_pkg::t_seg                 i_seg,
    output logic                          o_res_valid,
    output lsa_pkg::t_res                 o_res,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lsa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lsa_pkg::CFG_W-1:0]     i_cfg_data
);
    import lsa_pkg::*;

    // Configuration
    logic [CFG_W-1:0] r_frame_height;
    logic [CFG_W-1:0] r_top_row;

    // Per-side accumulators: sums in start_x, start_y, end_x, end_y order
    logic [SUM_W-1:0] r_sum [2][4];
    logic [CNT_W-1:0] r_cnt [2];

    // Sequencer
    t_lsa_state r_state, n_state;
    logic       r_side;
    logic [1:0] r_mi;
    logic       r_row;

    // Frame-end datapath
    logic        [COORD_W-1:0] r_mean [4];
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [OUT_W-1:0]   r_top [2];
    logic signed [OUT_W-1:0]   r_bot [2];
    logic                      r_vld [2];

    // Segment classification
    logic [COORD_W-1:0]      seg_coord [4];
    logic signed [DIFF_W-1:0] seg_dx, seg_dy;
    logic [COORD_W-1:0]      seg_adx, seg_ady;
    logic                    seg_keep;
    logic                    seg_side;
    logic                    seg_accept;
    logic                    seg_add;

    // Extrapolation terms
    logic signed [DIFF_W-1:0]   den, dlt, row_off;
    logic [CFG_W-1:0]           row_sel;
    logic signed [DIFF_W-1:0]   mul_a, mul_b;
    logic signed [2*DIFF_W-1:0] prod;
    logic [ACC_W-1:0]           acc_mag;
    logic [DIFF_W-1:0]          den_mag;
    logic                       q_neg;
    logic signed [OUT_W-1:0]    x_sat;

    t_div_req div_req;
    t_div_rsp div_rsp;

    lsa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Classify the incoming segment
    always_comb begin
        seg_coord[0] = i_seg.start_x;
        seg_coord[1] = i_seg.start_y;
        seg_coord[2] = i_seg.end_x;
        seg_coord[3] = i_seg.end_y;
        seg_dx  = $signed({1'b0, i_seg.end_x}) - $signed({1'b0, i_seg.start_x});
        seg_dy  = $signed({1'b0, i_seg.end_y}) - $signed({1'b0, i_seg.start_y});
        seg_adx = seg_dx[DIFF_W-1] ? COORD_W'(-seg_dx) : COORD_W'(seg_dx);
        seg_ady = seg_dy[DIFF_W-1] ? COORD_W'(-seg_dy) : COORD_W'(seg_dy);
        seg_keep = ({seg_ady, 1'b0} >= {1'b0, seg_adx});
        // Left for opposite slope signs, or a vertical segment pointing up
        if ((seg_dx < 0 && seg_dy > 0) || (seg_dx > 0 && seg_dy < 0)
                || (seg_dx == 0 && seg_dy < 0)) begin
            seg_side = 1'b0;
        end else begin
            seg_side = 1'b1;
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign seg_accept  = start && !busy;
    assign seg_add     = seg_accept && seg_keep
                         && (r_cnt[seg_side] < CNT_W'(MAX_SEGMENTS));
    assign o_cfg_ready = !busy;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_height <= FRAME_HEIGHT_RST;
            r_top_row      <= TOP_ROW_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                CFG_TOP_ROW:      r_top_row      <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // Accumulate kept segments; clear after the result goes out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || r_state == S_OUT) begin
            for (int s = 0; s < 2; s++) begin
                r_cnt[s] <= '0;
                for (int k = 0; k < 4; k++) begin
                    r_sum[s][k] <= '0;
                end
            end
        end else if (seg_add) begin
            r_cnt[seg_side] <= r_cnt[seg_side] + CNT_W'(1);
            for (int k = 0; k < 4; k++) begin
                r_sum[seg_side][k] <= r_sum[seg_side][k] + SUM_W'(seg_coord[k]);
            end
        end
    end

    // Mean line terms and the shared multiplier
    always_comb begin
        den     = $signed({1'b0, r_mean[3]}) - $signed({1'b0, r_mean[1]});
        dlt     = $signed({1'b0, r_mean[2]}) - $signed({1'b0, r_mean[0]});
        row_sel = r_row ? r_frame_height : r_top_row;
        row_off = $signed({1'b0, row_sel}) - $signed({1'b0, r_mean[1]});
        if (r_state == S_MULA) begin
            mul_a = $signed({1'b0, r_mean[0]});
            mul_b = den;
        end else begin
            mul_a = row_off;
            mul_b = dlt;
        end
        prod    = mul_a * mul_b;
        acc_mag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        den_mag = den[DIFF_W-1] ? DIFF_W'(-den) : DIFF_W'(den);
        q_neg   = r_acc[ACC_W-1] ^ den[DIFF_W-1];
    end

    // Divider request: means first, then the extrapolated positions
    always_comb begin
        div_req.start = (r_state == S_MEAN) || (r_state == S_XDIV);
        if (r_state == S_XDIV) begin
            div_req.dividend = acc_mag[NUM_W-1:0];
            div_req.divisor  = DEN_W'(den_mag[COORD_W-1:0]);
        end else begin
            div_req.dividend = NUM_W'(r_sum[r_side][r_mi]);
            div_req.divisor  = DEN_W'(r_cnt[r_side]);
        end
    end

    // Apply sign and saturate the quotient magnitude
    always_comb begin
        if (!q_neg) begin
            x_sat = (div_rsp.quot > NUM_W'(32767)) ? 16'sh7FFF
                                                    : $signed(div_rsp.quot[OUT_W-1:0]);
        end else begin
            x_sat = (div_rsp.quot > NUM_W'(32768)) ? 16'sh8000
                                                    : $signed(~div_rsp.quot[OUT_W-1:0]
                                                              + 16'd1);
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (seg_accept && i_seg.last_segment) n_state = S_SIDE;
            end
            S_SIDE: begin
                if (r_cnt[r_side] == '0) begin
                    n_state = r_side ? S_OUT : S_SIDE;
                end else begin
                    n_state = S_MEAN;
                end
            end
            S_MEAN: n_state = S_MEAN_WT;
            S_MEAN_WT: begin
                if (div_rsp.done) n_state = (r_mi == 2'd3) ? S_SLOPE : S_MEAN;
            end
            S_SLOPE: begin
                if (den == '0) begin
                    n_state = r_side ? S_OUT : S_SIDE;
                end else begin
                    n_state = S_MULA;
                end
            end
            S_MULA: n_state = S_MULB;
            S_MULB: n_state = S_XDIV;
            S_XDIV: n_state = S_XDIV_WT;
            S_XDIV_WT: begin
                if (div_rsp.done) begin
                    if (!r_row)      n_state = S_MULA;
                    else if (r_side) n_state = S_OUT;
                    else             n_state = S_SIDE;
                end
            end
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= 1'b0;
            r_mi   <= '0;
            r_row  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: r_side <= 1'b0;
                S_SIDE: begin
                    r_mi <= '0;
                    if (r_cnt[r_side] == '0) r_side <= 1'b1;
                end
                S_MEAN_WT: begin
                    if (div_rsp.done) r_mi <= r_mi + 2'd1;
                end
                S_SLOPE: begin
                    r_row <= 1'b0;
                    if (den == '0) r_side <= 1'b1;
                end
                S_XDIV_WT: begin
                    if (div_rsp.done) begin
                        r_row <= 1'b1;
                        if (r_row) r_side <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Frame-end datapath: means, products, saturated positions
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_SIDE: begin
                r_top[r_side] <= '0;
                r_bot[r_side] <= '0;
                r_vld[r_side] <= 1'b0;
            end
            S_MEAN_WT: begin
                if (div_rsp.done) r_mean[r_mi] <= div_rsp.quot[COORD_W-1:0];
            end
            S_MULA: r_acc <= ACC_W'(prod);
            S_MULB: r_acc <= r_acc + ACC_W'(prod);
            S_XDIV_WT: begin
                if (div_rsp.done) begin
                    if (r_row) begin
                        r_bot[r_side] <= x_sat;
                        r_vld[r_side] <= 1'b1;
                    end else begin
                        r_top[r_side] <= x_sat;
                    end
                end
            end
            default: ;
        endcase
    end

    // Result strobe
    assign o_res_valid          = (r_state == S_OUT);
    assign o_res.left_top_x     = r_top[0];
    assign o_res.left_bottom_x  = r_bot[0];
    assign o_res.right_top_x    = r_top[1];
    assign o_res.right_bottom_x = r_bot[1];
    assign o_res.left_valid     = r_vld[0];
    assign o_res.right_valid    = r_vld[1];

    // Checks
    logic chk_idle_clear;
    logic chk_div_wait;
    logic chk_cnt_bound;

    assign chk_idle_clear = !busy && r_cnt[0] == '0 && r_cnt[1] == '0;
    assign chk_div_wait   = (r_state == S_MEAN_WT) || (r_state == S_XDIV_WT);
    assign chk_cnt_bound  = (r_cnt[0] <= CNT_W'(MAX_SEGMENTS))
                            && (r_cnt[1] <= CNT_W'(MAX_SEGMENTS));

    `LSA_ASSERT(a_last_goes_busy, i_clk, i_rst_n, seg_accept && i_seg.last_segment |=> busy)
    `LSA_ASSERT(a_res_clears, i_clk, i_rst_n, o_res_valid |=> chk_idle_clear)
    `LSA_ASSERT(a_div_done_wait, i_clk, i_rst_n, div_rsp.done |-> chk_div_wait)
    `LSA_ASSERT_MSG(a_cnt_bound, i_clk, i_rst_n, chk_cnt_bound, "side count above limit")

endmodule

@@ dv/lane_segment_averager_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the lane segment averager: tracks register writes and accepted
// segments, predicts each frame result and compares it with the result strobe.
// Depends on lsa_pkg for the segment, result and register definitions.

module lane_segment_averager_checker
    import lsa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  t_seg                 i_seg,
    input  logic                 i_res_valid,
    input  t_res                 i_res,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef enum int {SIDE_LEFT = 0, SIDE_RIGHT = 1} t_side;

    // Shadow registers and per-side accumulators
    logic [CFG_W-1:0] bottom_row;
    logic [CFG_W-1:0] upper_row;
    logic [SUM_W-1:0] acc_sx [2];
    logic [SUM_W-1:0] acc_sy [2];
    logic [SUM_W-1:0] acc_ex [2];
    logic [SUM_W-1:0] acc_ey [2];
    logic [CNT_W-1:0] acc_n  [2];

    // Frame results still owed by the block, oldest first
    t_res lane_q [$];
    int   fails = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fails++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    function automatic void clear_acc();
        for (int k = 0; k < 2; k++) begin
            acc_sx[k] = '0;
            acc_sy[k] = '0;
            acc_ex[k] = '0;
            acc_ey[k] = '0;
            acc_n[k]  = '0;
        end
    endfunction

    // Drop flat segments, pick a side by slope sign, add unless the side is full
    function automatic void add_segment(input t_seg s);
        longint dx, dy, adx, ady;
        t_side  side;
        dx  = longint'(s.end_x) - longint'(s.start_x);
        dy  = longint'(s.end_y) - longint'(s.start_y);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        if (2 * ady < adx)
            return;
        if ((dx < 0 && dy > 0) || (dx > 0 && dy < 0) || (dx == 0 && dy < 0))
            side = SIDE_LEFT;
        else
            side = SIDE_RIGHT;
        if (acc_n[side] < CNT_W'(MAX_SEGMENTS)) begin
            acc_sx[side] += SUM_W'(s.start_x);
            acc_sy[side] += SUM_W'(s.start_y);
            acc_ex[side] += SUM_W'(s.end_x);
            acc_ey[side] += SUM_W'(s.end_y);
            acc_n[side]  += CNT_W'(1);
        end
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp_col(input longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return OUT_W'(v);
    endfunction

    // Mean line of one side extrapolated to both rows; empty or flat side is invalid
    function automatic void fit_side(input t_side side,
                                     output logic signed [OUT_W-1:0] x_top,
                                     output logic signed [OUT_W-1:0] x_bot,
                                     output logic ok);
        longint n, mx1, my1, mx2, my2, den, d;
        x_top = '0;
        x_bot = '0;
        ok    = 1'b0;
        if (acc_n[side] == '0)
            return;
        n   = longint'(acc_n[side]);
        mx1 = longint'(acc_sx[side]) / n;
        my1 = longint'(acc_sy[side]) / n;
        mx2 = longint'(acc_ex[side]) / n;
        my2 = longint'(acc_ey[side]) / n;
        den = my2 - my1;
        if (den == 0)
            return;
        d     = mx2 - mx1;
        x_top = clamp_col((mx1 * den + (longint'(upper_row) - my1) * d) / den);
        x_bot = clamp_col((mx1 * den + (longint'(bottom_row) - my1) * d) / den);
        ok    = 1'b1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_res want;
        t_res made;
        if (!i_rst_n) begin
            bottom_row = FRAME_HEIGHT_RST;
            upper_row  = TOP_ROW_RST;
            clear_acc();
            lane_q.delete();
        end else begin
            // Compare a result strobe with the oldest owed frame
            if (i_res_valid) begin
                if (lane_q.size() == 0) begin
                    report_mismatch("result strobe with no frame pending");
                end else begin
                    want = lane_q.pop_front();
                    check_field("left_top_x", i_res.left_top_x, want.left_top_x);
                    check_field("left_bottom_x", i_res.left_bottom_x, want.left_bottom_x);
                    check_field("right_top_x", i_res.right_top_x, want.right_top_x);
                    check_field("right_bottom_x", i_res.right_bottom_x,
                                want.right_bottom_x);
                    check_field("left_valid", i_res.left_valid, want.left_valid);
                    check_field("right_valid", i_res.right_valid, want.right_valid);
                end
            end
            // Track register writes
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_FRAME_HEIGHT)
                    bottom_row = i_cfg_data;
                else if (i_cfg_index == CFG_TOP_ROW)
                    upper_row = i_cfg_data;
            end
            // Accumulate each accepted segment; close the frame on its last one
            if (i_start && !i_busy) begin
                add_segment(i_seg);
                if (i_seg.last_segment) begin
                    fit_side(SIDE_LEFT, made.left_top_x, made.left_bottom_x,
                             made.left_valid);
                    fit_side(SIDE_RIGHT, made.right_top_x, made.right_bottom_x,
                             made.right_valid);
                    lane_q = {lane_q, made};
                    clear_acc();
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= lane_q.size();
    end

endmodule

@@ dv/lane_segment_averager_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for lane_segment_averager_core: drives segment frames and row
// register writes, and reports the verdict of lane_segment_averager_checker.
// Depends on lsa_pkg, the core RTL and the checker module.

module lane_segment_averager_core_tb;
    import lsa_pkg::*;

    localparam int RAND_ITEMS      = 480;
    localparam int MIN_RAND_FRAMES = 40;
    localparam int FULL_FRAME_LEN  = 270;
    localparam int CALM_ITEMS      = 60;
    localparam int SETTLE_CYCLES   = 8;
    localparam int END_CYCLES      = 400;
    localparam int WATCHDOG_LIMIT  = 4000;

    typedef enum int {MIX_ANY, MIX_LEFT_LANE} t_mix;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    t_seg                 seg;
    logic                 res_valid;
    t_res                 res;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int fail_count;
    int res_pending;
    int stall_cycles = 0;
    int items_sent   = 0;
    int frames_sent  = 0;
    bit calm         = 1'b0;

    lane_segment_averager_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_seg       (seg),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    lane_segment_averager_checker lane_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_seg        (seg),
        .i_res_valid  (res_valid),
        .i_res        (res),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (res_pending)
    );

    initial clk = 1'b0;
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // End the run when no transaction of any kind moves for too long
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || res_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_seg mk_seg(input int x1, input int y1, input int x2, input int y2,
                                    input bit last);
        t_seg s;
        s.start_x      = COORD_W'(x1);
        s.start_y      = COORD_W'(y1);
        s.end_x        = COORD_W'(x2);
        s.end_y        = COORD_W'(y2);
        s.last_segment = last;
        return s;
    endfunction

    // Steep lane-like segment; endpoints swapped half the time
    function automatic t_seg rand_lane(input bit to_left);
        int x1, y1, x2, y2, reach;
        y1    = $urandom_range(4095, 1);
        y2    = $urandom_range(y1 - 1, 0);
        reach = 2 * (y1 - y2);
        x1    = $urandom_range(4095, 0);
        if (to_left)
            x2 = x1 + $urandom_range((reach < 4095 - x1) ? reach : 4095 - x1, 0);
        else
            x2 = x1 - $urandom_range((reach < x1) ? reach : x1, 0);
        if ($urandom_range(1, 0))
            return mk_seg(x2, y2, x1, y1, 1'b0);
        return mk_seg(x1, y1, x2, y2, 1'b0);
    endfunction

    function automatic int edge_coord();
        case ($urandom_range(3, 0))
            0:       return 0;
            1:       return 4095;
            2:       return 1;
            default: return 4094;
        endcase
    endfunction

    // Left lanes only, or mostly lanes on both sides with noise, flats, points, edges
    function automatic t_seg rand_seg(input t_mix mix);
        int pick, x1, y1;
        if (mix == MIX_LEFT_LANE)
            return rand_lane(1'b1);
        pick = $urandom_range(99, 0);
        if (pick < 40)
            return rand_lane(1'b1);
        if (pick < 80)
            return rand_lane(1'b0);
        if (pick < 88)
            return mk_seg($urandom_range(4095, 0), $urandom_range(4095, 0),
                          $urandom_range(4095, 0), $urandom_range(4095, 0), 1'b0);
        x1 = $urandom_range(2047, 0);
        y1 = $urandom_range(3800, 0);
        if (pick < 93)
            return mk_seg(x1, y1, x1 + $urandom_range(2048, 1024),
                          y1 + $urandom_range(200, 0), 1'b0);
        if (pick < 96)
            return mk_seg(x1, y1, x1, y1, 1'b0);
        return mk_seg(edge_coord(), edge_coord(), edge_coord(), edge_coord(), 1'b0);
    endfunction

    // Present one segment and hold it until the block takes it
    task automatic send_seg(input t_seg s);
        seg   <= s;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic maybe_pause(input bit quiet);
        if (calm || quiet || $urandom_range(9, 0) > 2)
            return;
        start <= 1'b0;
        repeat ($urandom_range(11, 1))
            @(posedge clk);
    endtask

    task automatic send_frame(input int len, input t_mix mix, input bit quiet);
        t_seg s;
        for (int k = 0; k < len; k++) begin
            s              = rand_seg(mix);
            s.last_segment = (k == len - 1);
            maybe_pause(quiet);
            send_seg(s);
        end
        frames_sent++;
    endtask

    // Drop start and wait until every owed result has come back
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (res_pending != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_rows(input int height, input int row);
        wait_drained();
        write_reg(CFG_FRAME_HEIGHT, CFG_W'(height));
        write_reg(CFG_TOP_ROW, CFG_W'(row));
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_rows();
        int h;
        case ($urandom_range(6, 0))
            0: set_rows(540, 324);
            1: set_rows(4095, 0);
            2: set_rows(1, 0);
            3: set_rows(4095, 4095);
            4: set_rows(1, 4095);
            5: begin
                h = $urandom_range(4095, 1);
                set_rows(h, h * 6 / 10);
            end
            default: set_rows($urandom_range(4095, 1), $urandom_range(4095, 0));
        endcase
    endtask

    initial begin : stimulus
        int base_items;
        int base_frames;
        int len;
        rst_n     = 1'b0;
        start     = 1'b0;
        seg       = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FRAME_HEIGHT;
        cfg_data  = '0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One left and one right lane at the reset rows
        send_seg(mk_seg(100, 500, 300, 300, 1'b0));
        send_seg(mk_seg(3000, 300, 3200, 500, 1'b1));
        // Flat segment only: both sides empty
        send_seg(mk_seg(0, 0, 4095, 0, 1'b1));
        // Zero-length segment alone: right side, horizontal mean
        send_seg(mk_seg(4095, 4095, 4095, 4095, 1'b1));
        // Vertical segments: upward goes left, downward goes right
        send_seg(mk_seg(0, 4095, 0, 0, 1'b0));
        send_seg(mk_seg(2000, 0, 2000, 4095, 1'b1));
        // Left pair whose mean line is horizontal
        send_seg(mk_seg(100, 100, 90, 120, 1'b0));
        send_seg(mk_seg(100, 120, 110, 100, 1'b1));
        // Slope threshold: kept exactly at it, dropped just past it; corner diagonals
        send_seg(mk_seg(0, 0, 2, 1, 1'b0));
        send_seg(mk_seg(0, 0, 3, 1, 1'b0));
        send_seg(mk_seg(4095, 0, 0, 4095, 1'b0));
        send_seg(mk_seg(0, 0, 4095, 4095, 1'b1));
        // Nearly flat left mean line: positions saturate
        send_seg(mk_seg(0, 2000, 2000, 1000, 1'b0));
        send_seg(mk_seg(4000, 0, 3000, 1003, 1'b1));
        set_rows(4095, 0);
        send_seg(mk_seg(0, 2000, 2000, 1000, 1'b0));
        send_seg(mk_seg(4000, 0, 3000, 1003, 1'b1));
        set_rows(1, 4095);
        send_seg(mk_seg(1000, 4000, 1500, 2000, 1'b0));
        send_seg(mk_seg(3500, 4000, 3000, 2000, 1'b1));

        // Random frames, one of them overfilling the left side
        base_items  = items_sent;
        base_frames = frames_sent;
        while (items_sent - base_items < RAND_ITEMS ||
               frames_sent - base_frames < MIN_RAND_FRAMES) begin
            calm = (items_sent - base_items >= RAND_ITEMS - CALM_ITEMS);
            if ((frames_sent - base_frames) % 8 == 4 && !calm)
                pick_rows();
            if (frames_sent - base_frames == 2) begin
                send_frame(FULL_FRAME_LEN, MIX_LEFT_LANE, 1'b0);
            end else begin
                len = ($urandom_range(3, 0) == 0) ? 1 : $urandom_range(12, 2);
                send_frame(len, MIX_ANY, $urandom_range(3, 0) == 0);
            end
        end

        wait_drained();
        repeat (END_CYCLES)
            @(posedge clk);
        if (fail_count == 0 && res_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
